FILE: sv/lnse_pkg.sv
// Shared types and constants for the lognormal size-effect unit.
// No dependencies; the files that use this package refer to it by scoped names.
`default_nettype none
package lnse_pkg;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  localparam int LOG_ITERS = 16;
  localparam int DIV_STEPS = 20;
  localparam int EXP_TERMS = 12;

  // ln(2)/2 and ln(2) as Q0.32.
  localparam logic [30:0] HALF_LN2_Q32 = 31'd1488522236;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;

  // floor(2^35 / k) for the series divisions by k.
  localparam logic [35:0] RECIP [1:12] = '{
    36'd34359738368, 36'd17179869184, 36'd11453246122, 36'd8589934592,
    36'd6871947673,  36'd5726623061,  36'd4908534052,  36'd4294967296,
    36'd3817748707,  36'd3435973836,  36'd3123612578,  36'd2863311530
  };

  // Sideband that travels with every item down the pipeline.
  typedef struct packed {
    logic        valid;
    logic        perr;   // parameter error of a write
    logic        zero;   // result is forced to zero
    logic [3:0]  n;      // integer part of the exponent
    logic [30:0] sq;     // Xb squared
  } ctl_t;

endpackage
`default_nettype wire

FILE: sv/lognormal_size_effect_unit.sv
// Top level of the lognormal size-effect unit: species parameter memories,
// log-ratio and scaling stages, and output register.
// Depends on lnse_pkg, lnse_ram, lnse_log2, lnse_div and lnse_exp.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+------------------------------------
//  in      | input     | in_valid/in_ready   | req_type, species, diameter,
//          |           |                     | mode_value, spread_value
//  out     | output    | out_valid/out_ready | size_effect, param_error
//
// One item is taken per cycle while the output is not stalled, and each gives
// exactly one result; the depth is set by the memory read, the sixteen log2
// squaring stages, the twenty divider stages and the three stages per
// exponential series term. Reset is synchronous and active low and clears only
// the valid bits; the species memories hold nothing until written. The whole
// pipeline advances together whenever the output register is empty or being
// taken, so a stall on the output side holds every stage in place.
`default_nettype none
module lognormal_size_effect_unit #(
  parameter int NUM_SPECIES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req_type,
  input  wire logic [7:0]         in_species,
  input  wire logic [15:0]        in_diameter,
  input  wire logic [15:0]        in_mode_value,
  input  wire logic signed [15:0] in_spread_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_size_effect,
  output logic                    out_param_error
);
  localparam int AW  = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
  localparam int SPW = (AW > 8) ? AW : 8;

  // Global pipeline enable: everything moves when the output slot frees up.
  logic en;
  logic accept;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  // Decode of the incoming transfer.
  logic [SPW-1:0] sp_ext;
  logic [AW-1:0]  addr;
  logic           in_range;
  logic           bad;
  logic           is_write;
  assign sp_ext   = SPW'(in_species);
  assign addr     = sp_ext[AW-1:0];
  assign in_range = 32'(in_species) < 32'(NUM_SPECIES);
  assign bad      = (in_mode_value == 16'd0) || (in_spread_value == 16'sd0);
  assign is_write = in_req_type == lnse_pkg::REQ_WRITE;

  // The tables are written as the write transfer is taken, so an evaluate that
  // follows in the next cycle already reads the new entry.
  logic        we;
  logic [15:0] mode_rd;
  logic [15:0] spread_rd;
  assign we = accept && is_write && !bad && in_range;

  lnse_ram #(.WIDTH(16), .DEPTH(NUM_SPECIES)) u_mode_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (in_mode_value),
    .re    (accept),
    .raddr (addr),
    .rdata (mode_rd)
  );

  lnse_ram #(.WIDTH(16), .DEPTH(NUM_SPECIES)) u_spread_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (in_spread_value),
    .re    (accept),
    .raddr (addr),
    .rdata (spread_rd)
  );

  // Stage 0 lines up with the memory read.
  logic        v0_r;
  logic        perr0_r;
  logic        zero0_r;
  logic [15:0] d0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      perr0_r <= is_write && bad;
      // Writes always report zero; so do a zero diameter and an unknown species.
      zero0_r <= is_write || (in_diameter == 16'd0) || !in_range;
      d0_r    <= in_diameter;
    end
  end

  logic signed [31:0] sq_full;
  lnse_pkg::ctl_t     ctl_s1;
  assign sq_full = $signed(spread_rd) * $signed(spread_rd);

  always_comb begin
    ctl_s1.valid = v0_r;
    ctl_s1.perr  = perr0_r;
    ctl_s1.zero  = zero0_r || (mode_rd == 16'd0) || (spread_rd == 16'd0);
    ctl_s1.n     = '0;
    ctl_s1.sq    = sq_full[30:0];
  end

  logic [19:0]    ld;
  logic [19:0]    lx;
  lnse_pkg::ctl_t ctl_log;

  lnse_log2 u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .d_in    (d0_r),
    .x0_in   (mode_rd),
    .ctl_in  (ctl_s1),
    .ld_out  (ld),
    .lx_out  (lx),
    .ctl_out (ctl_log)
  );

  // The Q9.7 scaling cancels in the difference of the two logarithms.
  logic signed [20:0] l_diff;
  logic [19:0]        l_abs;
  logic [39:0]        l_sq;
  logic [31:0]        q_r;
  lnse_pkg::ctl_t     ctl_p1_r;
  assign l_diff = $signed({1'b0, ld}) - $signed({1'b0, lx});
  assign l_abs  = l_diff[20] ? 20'(-l_diff) : l_diff[19:0];
  assign l_sq   = 40'(l_abs) * 40'(l_abs);

  // Scale by ln(2)/2; the factor 2^16 of the divisor is taken out here.
  logic [62:0]    p_full;
  logic [46:0]    p_r;
  lnse_pkg::ctl_t ctl_p2_r;
  assign p_full = 63'(q_r) * 63'(lnse_pkg::HALF_LN2_Q32);

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= l_sq[39:8];
      p_r <= p_full[62:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_p1_r.valid <= 1'b0;
      ctl_p2_r.valid <= 1'b0;
    end else if (en) begin
      ctl_p1_r <= ctl_log;
      ctl_p2_r <= ctl_p1_r;
    end
  end

  logic [15:0]    f;
  lnse_pkg::ctl_t ctl_div;

  lnse_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .p_in    (p_r),
    .ctl_in  (ctl_p2_r),
    .f_out   (f),
    .ctl_out (ctl_div)
  );

  logic [33:0]    e;
  lnse_pkg::ctl_t ctl_exp;

  lnse_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .f_in    (f),
    .ctl_in  (ctl_div),
    .e_out   (e),
    .ctl_out (ctl_exp)
  );

  // Apply 2^-n with round half up and clamp to one. The shift reaches 32 when
  // n is fifteen, so the shift amounts carry six bits.
  logic [33:0] rnd_sum;
  logic [33:0] y;
  logic [15:0] res;
  assign rnd_sum = e + (34'd1 << (6'd16 + 6'(ctl_exp.n)));
  assign y       = rnd_sum >> (6'd17 + 6'(ctl_exp.n));
  assign res     = ctl_exp.zero ? 16'd0 :
                   (y > 34'd32768) ? 16'd32768 : y[15:0];

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_se_r;
  logic        out_pe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_exp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_se_r <= res;
      out_pe_r <= ctl_exp.perr;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_size_effect = out_se_r;
  assign out_param_error = out_pe_r;
endmodule
`default_nettype wire

FILE: sv/lnse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lnse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: sv/lnse_log2.sv
// Two-lane pipelined log2 (Q4.16) by repeated squaring, one fraction bit per stage.
// Depends on lnse_pkg.
`default_nettype none
module lnse_log2 (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic [15:0]     d_in,
  input  wire logic [15:0]     x0_in,
  input  wire lnse_pkg::ctl_t  ctl_in,
  output logic      [19:0]     ld_out,
  output logic      [19:0]     lx_out,
  output lnse_pkg::ctl_t       ctl_out
);
  localparam int N = lnse_pkg::LOG_ITERS;

  function automatic logic [3:0] lead_one(input logic [15:0] v);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) k = 4'(i);
    end
    return k;
  endfunction

  logic [1:0][15:0] val;
  logic [30:0]      m_r [2][N+1];
  logic [3:0]       k_r [2][N+1];
  logic [15:0]      f_r [2][N+1];
  lnse_pkg::ctl_t   ctl_r [N+1];

  assign val = {x0_in, d_in};

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic [3:0] k0;
    assign k0 = lead_one(val[ln]);

    always_ff @(posedge clk) begin
      if (en) begin
        k_r[ln][0] <= k0;
        m_r[ln][0] <= 31'(val[ln]) << (5'd30 - {1'b0, k0});
        f_r[ln][0] <= '0;
      end
    end

    for (genvar s = 1; s <= N; s++) begin : g_stage
      logic [61:0] prod;
      logic [31:0] mm;
      assign prod = 62'(m_r[ln][s-1]) * 62'(m_r[ln][s-1]);
      assign mm   = prod[61:30];
      always_ff @(posedge clk) begin
        if (en) begin
          k_r[ln][s] <= k_r[ln][s-1];
          m_r[ln][s] <= mm[31] ? mm[31:1] : mm[30:0];
          f_r[ln][s] <= {f_r[ln][s-1][14:0], mm[31]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= N; s++) ctl_r[s].valid <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= ctl_in;
      for (int s = 1; s <= N; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  assign ld_out  = {k_r[0][N], f_r[0][N]};
  assign lx_out  = {k_r[1][N], f_r[1][N]};
  assign ctl_out = ctl_r[N];
endmodule
`default_nettype wire

FILE: sv/lnse_div.sv
// Pipelined restoring divider: u = p / Xb^2, one quotient bit per stage, with
// an overflow flag once u reaches 16.0. Depends on lnse_pkg.
`default_nettype none
module lnse_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic [46:0]     p_in,
  input  wire lnse_pkg::ctl_t  ctl_in,
  output logic      [15:0]     f_out,
  output lnse_pkg::ctl_t       ctl_out
);
  localparam int N = lnse_pkg::DIV_STEPS;

  logic [46:0]    rem_r [N+1];
  logic [N-1:0]   q_r   [N+1];
  lnse_pkg::ctl_t ctl_r [N+1];
  logic           ovf;
  lnse_pkg::ctl_t ctl_ovf;

  assign ovf = {4'b0, p_in} >= (51'(ctl_in.sq) << N);

  // An overflowing quotient forces the result to zero.
  always_comb begin
    ctl_ovf      = ctl_in;
    ctl_ovf.zero = ctl_in.zero | ovf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= p_in;
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 1; s <= N; s++) begin : g_stage
    logic [50:0] sh;
    logic [50:0] cand;
    logic        ge;
    assign sh   = 51'(ctl_r[s-1].sq) << (N - s);
    assign cand = {4'b0, rem_r[s-1]};
    assign ge   = cand >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? 47'(cand - sh) : rem_r[s-1];
        q_r[s]   <= {q_r[s-1][N-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= N; s++) ctl_r[s].valid <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= ctl_ovf;
      for (int s = 1; s <= N; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  always_comb begin
    ctl_out   = ctl_r[N];
    ctl_out.n = q_r[N][19:16];
  end
  assign f_out = q_r[N][15:0];
endmodule
`default_nettype wire

FILE: sv/lnse_exp.sv
// Pipelined exp(-x) in Q0.32 by a twelve-term series, three stages per term
// (product, reciprocal multiply, correction and accumulate). Depends on lnse_pkg.
`default_nettype none
module lnse_exp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic [15:0]     f_in,
  input  wire lnse_pkg::ctl_t  ctl_in,
  output logic      [33:0]     e_out,
  output lnse_pkg::ctl_t       ctl_out
);
  localparam int K = lnse_pkg::EXP_TERMS;

  logic [47:0] xprod;
  assign xprod = 48'(f_in) * 48'(lnse_pkg::LN2_Q32);

  // Values at term boundaries.
  logic [31:0]    x_r    [K+1];
  logic [32:0]    term_r [K+1];
  logic [33:0]    sum_r  [K+1];
  lnse_pkg::ctl_t ctl_r  [K+1];
  // Inside a term: after the product stage (a) and the reciprocal stage (b).
  logic [31:0]    xa_r [1:K], xb_r [1:K];
  logic [33:0]    sa_r [1:K], sb_r [1:K];
  logic [31:0]    ta_r [1:K], tb_r [1:K], qb_r [1:K];
  lnse_pkg::ctl_t ca_r [1:K], cb_r [1:K];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= xprod[47:16];
      term_r[0] <= 33'h1_0000_0000;
      sum_r[0]  <= 34'h1_0000_0000;
    end
  end

  for (genvar k = 1; k <= K; k++) begin : g_term
    logic [64:0] tprod;
    logic [67:0] rprod;
    logic [35:0] rem;
    logic [32:0] nterm;
    assign tprod = 65'(term_r[k-1]) * 65'(x_r[k-1]);
    assign rprod = 68'(ta_r[k]) * 68'(lnse_pkg::RECIP[k]);
    assign rem   = 36'(tb_r[k]) - 36'(qb_r[k]) * 36'(k);
    assign nterm = (rem >= 36'(k)) ? 33'(qb_r[k]) + 33'd1 : 33'(qb_r[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        ta_r[k]   <= tprod[63:32];
        xa_r[k]   <= x_r[k-1];
        sa_r[k]   <= sum_r[k-1];
        tb_r[k]   <= ta_r[k];
        qb_r[k]   <= rprod[66:35];
        xb_r[k]   <= xa_r[k];
        sb_r[k]   <= sa_r[k];
        term_r[k] <= nterm;
        x_r[k]    <= xb_r[k];
        sum_r[k]  <= (k % 2 == 1) ? sb_r[k] - 34'(nterm) : sb_r[k] + 34'(nterm);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ca_r[k].valid  <= 1'b0;
        cb_r[k].valid  <= 1'b0;
        ctl_r[k].valid <= 1'b0;
      end else if (en) begin
        ca_r[k]  <= ctl_r[k-1];
        cb_r[k]  <= ca_r[k];
        ctl_r[k] <= cb_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].valid <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= ctl_in;
    end
  end

  assign e_out   = sum_r[K];
  assign ctl_out = ctl_r[K];
endmodule
`default_nettype wire

FILE: tb/lnse_checker.sv
// Watches both channels of the lognormal size-effect unit, predicts each result
// from its own copy of the species table, and counts mismatches.
// Depends on nothing but the port widths of lognormal_size_effect_unit.
module lnse_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_species,
  input  logic [15:0] in_diameter,
  input  logic [15:0] in_mode_value,
  input  logic [15:0] in_spread_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_size_effect,
  input  logic        out_param_error,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] size_effect;
    logic        param_error;
  } effect_t;

  effect_t     effect_q[$];
  logic [15:0] mode_mem [256];
  logic [15:0] spread_mem [256];

  // log2 of a nonzero 16-bit value as Q4.16, by repeated squaring.
  function automatic longint log2_q16(logic [15:0] v);
    int k;
    longint unsigned m;
    longint unsigned frac;
    k = 15;
    frac = 0;
    while (k > 0 && v[k] == 1'b0) k--;
    m = longint'(v) << (30 - k);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(k) * 65536 + longint'(frac);
  endfunction

  function automatic logic [15:0] size_effect_of(logic [15:0] d, logic [15:0] x0,
                                                 logic [15:0] xb);
    longint l;
    longint sxb;
    longint unsigned al, q, den, u, n, f, x, term, sum, y;
    int s;
    if (d == 0 || x0 == 0 || xb == 0) return 16'd0;
    sxb = longint'($signed(xb));
    l = log2_q16(d) - log2_q16(x0);
    al = (l < 0) ? -l : l;
    q = (al * al) >> 8;
    den = longint'(sxb * sxb) << 16;
    u = (q * 64'd1488522236) / den;
    n = u >> 16;
    if (n >= 16) return 16'd0;
    f = u & 64'hFFFF;
    x = (f * 64'd2977044472) >> 16;
    term = 64'd1 << 32;
    sum = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * x) >> 32) / k;
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    s = 17 + int'(n);
    y = (sum + (64'd1 << (s - 1))) >> s;
    if (y > 32768) y = 32768;
    return y[15:0];
  endfunction

  always @(posedge clk) begin : watch
    effect_t want;
    logic    bad;
    if (!rst_n) begin
      effect_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_req_type == 1'b0) begin
          bad = (in_mode_value == 0) || (in_spread_value == 0);
          if (!bad) begin
            mode_mem[in_species]   = in_mode_value;
            spread_mem[in_species] = in_spread_value;
          end
          want.size_effect = 16'd0;
          want.param_error = bad;
        end else begin
          want.size_effect = size_effect_of(in_diameter, mode_mem[in_species],
                                            spread_mem[in_species]);
          want.param_error = 1'b0;
        end
        effect_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (effect_q.size() == 0) begin
          $display("%0t: unexpected result size_effect %0d param_error %0d",
                   $time, out_size_effect, out_param_error);
          fail_count <= fail_count + 1;
        end else begin
          want = effect_q.pop_front();
          if (want.size_effect !== out_size_effect) begin
            $display("%0t: size_effect expected %0d actual %0d",
                     $time, want.size_effect, out_size_effect);
            fail_count <= fail_count + 1;
          end else if (want.param_error !== out_param_error) begin
            $display("%0t: param_error expected %0d actual %0d",
                     $time, want.param_error, out_param_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= effect_q.size();
  end
endmodule

FILE: tb/tb.sv
// Top of the testbench: clock, reset, stimulus with bursts and stalls, verdict.
// Depends on lognormal_size_effect_unit, lnse_pkg and lnse_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = lnse_pkg::REQ_WRITE;
  logic [7:0]  in_species = 8'd0;
  logic [15:0] in_diameter = 16'd0;
  logic [15:0] in_mode_value = 16'd0;
  logic [15:0] in_spread_value = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_size_effect;
  logic        out_param_error;
  int          fail_count;
  int          pending;

  // Set by the stimulus to ask the receiver for one long hold-off.
  logic        hold_request = 1'b0;

  // Species that hold valid parameters; only these are ever evaluated.
  logic [255:0] stored = '0;
  logic [7:0]   stored_list[$];
  logic [15:0]  mode_of [256];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lognormal_size_effect_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_species(in_species),
    .in_diameter(in_diameter), .in_mode_value(in_mode_value),
    .in_spread_value(in_spread_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_size_effect(out_size_effect), .out_param_error(out_param_error)
  );

  lnse_checker check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_species(in_species),
    .in_diameter(in_diameter), .in_mode_value(in_mode_value),
    .in_spread_value(in_spread_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_size_effect(out_size_effect), .out_param_error(out_param_error),
    .fail_count(fail_count), .pending(pending)
  );

  // The receiver alternates between always-ready stretches and random
  // stalling, and performs one long hold-off of its own when requested.
  always @(posedge clk) begin : receiver
    int phase_left;
    int stall_pct;
    int hold_left;
    if (!rst_n) begin
      phase_left = 0;
      stall_pct  = 0;
      hold_left  = 0;
      out_ready <= 1'b0;
    end else begin
      if (hold_request && hold_left == 0) begin
        hold_left = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(200, 10);
          case ($urandom_range(2, 0))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 80;
          endcase
        end
        phase_left--;
        out_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // The watchdog ends the run when no transfer happens for too long.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= 5000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offers one item from the current rising edge and returns at the edge at
  // which it is transferred. Ready is sampled at the falling edge so that the
  // decision never races the block's own updates.
  task automatic offer(logic req, logic [7:0] sp, logic [15:0] d, logic [15:0] x0,
                       logic [15:0] xb);
    logic rdy;
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_species      <= sp;
    in_diameter     <= d;
    in_mode_value   <= x0;
    in_spread_value <= xb;
    if (req == lnse_pkg::REQ_WRITE && x0 != 0 && xb != 0) begin
      if (!stored[sp]) stored_list.push_back(sp);
      stored[sp] = 1'b1;
      mode_of[sp] = x0;
    end
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic idle_for(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until every expected result has come back, then idles longer than the pipeline depth.
  task automatic drain();
    int seen;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      seen = pending;
      @(posedge clk);
    end while (seen != 0);
    repeat (150) @(posedge clk);
  endtask

  // A random item: mostly valid writes and evaluations of stored species with
  // diameters near the mode, where the curve is far from zero.
  task automatic random_item();
    logic [7:0]  sp;
    logic [15:0] d, x0, xb;
    int          pick;
    pick = $urandom_range(99, 0);
    if (pick < 25 || stored_list.size() == 0) begin
      sp = 8'($urandom());
      x0 = ($urandom_range(3, 0) == 0) ? 16'($urandom()) : 16'($urandom_range(4000, 1));
      case ($urandom_range(3, 0))
        0: xb = 16'($urandom());
        1: xb = 16'($urandom_range(8192, 256));
        2: xb = 16'(-$urandom_range(8192, 256));
        default: xb = 16'($urandom_range(2048, 1));
      endcase
      if (pick < 3) x0 = 16'd0;
      else if (pick < 6) xb = 16'd0;
      offer(lnse_pkg::REQ_WRITE, sp, 16'($urandom()), x0, xb);
    end else begin
      sp = stored_list[$urandom_range(stored_list.size() - 1, 0)];
      case ($urandom_range(4, 0))
        0: d = 16'($urandom());
        1: d = 16'd0;
        default: d = 16'(mode_of[sp] + $urandom_range(400, 0) - 200);
      endcase
      offer(lnse_pkg::REQ_EVAL, sp, d, 16'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin : stimulus
    int left, burst;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes of the parameters, both error cases and the
    // zero and extreme diameters.
    offer(lnse_pkg::REQ_WRITE, 8'd0,   16'd0, 16'd1,     16'd1);
    offer(lnse_pkg::REQ_WRITE, 8'd255, 16'd0, 16'hFFFF,  16'h8000);
    offer(lnse_pkg::REQ_WRITE, 8'd7,   16'd0, 16'd128,   16'd4096);
    offer(lnse_pkg::REQ_WRITE, 8'd8,   16'd0, 16'd2000,  16'h7FFF);
    offer(lnse_pkg::REQ_WRITE, 8'd9,   16'd0, 16'd640,   -16'd2048);
    offer(lnse_pkg::REQ_WRITE, 8'd7,   16'd0, 16'd0,     16'd4096);
    offer(lnse_pkg::REQ_WRITE, 8'd7,   16'd0, 16'd300,   16'd0);
    offer(lnse_pkg::REQ_WRITE, 8'd3,   16'd0, 16'd0,     16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd7,   16'd0,     16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd7,   16'd128,   16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd7,   16'd256,   16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd7,   16'd1,     16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd7,   16'hFFFF,  16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd0,   16'd1,     16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd0,   16'd2,     16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd255, 16'hFFFF,  16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd255, 16'h8000,  16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd8,   16'd2100,  16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd9,   16'd700,   16'd0, 16'd0);
    offer(lnse_pkg::REQ_EVAL,  8'd9,   16'd0,     16'hFFFF, 16'hFFFF);

    // The sender pauses until every expected result has come.
    drain();

    // The receiver holds off for a long stretch while items keep coming, so
    // the pipeline fills and the input stalls.
    hold_request = 1'b1;
    repeat (200) random_item();

    // Random part in bursts with random gaps.
    left = 800;
    while (left > 0) begin
      burst = $urandom_range(30, 1);
      for (int i = 0; i < burst && left > 0; i++) begin
        random_item();
        left--;
      end
      if ($urandom_range(3, 0) != 0) idle_for($urandom_range(12, 1));
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
